// ===== rtl/core/cls_pkg.sv =====
package cls_pkg;

  localparam int MODE_W   = 2;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 4;
  localparam int COUNT_W  = 5;
  localparam int STATUS_W = 2;

  typedef logic [MODE_W-1:0]   mode_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam mode_t MODE_APPEND = 2'd0;
  localparam mode_t MODE_READ   = 2'd1;
  localparam mode_t MODE_REMOVE = 2'd2;

  localparam status_t STAT_OK        = 2'd0;
  localparam status_t STAT_NOT_FOUND = 2'd1;
  localparam status_t STAT_FULL      = 2'd2;
  localparam status_t STAT_RANGE     = 2'd3;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_EXEC  = 6'b000010,
    ST_RWAIT = 6'b000100,
    ST_SCMP  = 6'b001000,
    ST_SHIFT = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

endpackage

// ===== rtl/core/compacting_list_store.sv =====
// Sequence: append, a rejected command or an unused mode runs in EXEC and then DONE;
// a read adds RWAIT, a remove scans in SCMP and SHIFT (one entry compared or moved per
// cycle, set by the one read port of the entry RAM); a stalled out_ready holds DONE.
// Throughput: one command at a time; in_ready is high only while the sequencer idles.
// Reset: synchronous, active low; clears count, sequencer and out_valid.
// Entry RAM contents stay undefined until written.
module compacting_list_store #(
  parameter int CAPACITY   = 16,
  parameter int ITEM_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [cls_pkg::MODE_W-1:0]     in_mode,
  input  logic [cls_pkg::VALUE_W-1:0]    in_item_value,
  input  logic [cls_pkg::POS_W-1:0]      in_position,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [cls_pkg::VALUE_W-1:0]    out_read_value,
  output logic [cls_pkg::COUNT_W-1:0]    out_entry_count,
  output logic [cls_pkg::STATUS_W-1:0]   out_status
);

  import cls_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int SW = (ITEM_WIDTH < VALUE_W) ? ITEM_WIDTH : VALUE_W;

  state_t          state_r, state_nxt;
  mode_t           mode_r, mode_nxt;
  logic [SW-1:0]   val_r, val_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [AW-1:0]   idx_r, idx_nxt;
  logic [SW-1:0]   res_val_r, res_val_nxt;
  status_t         res_stat_r, res_stat_nxt;

  logic            out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0]  out_val_r, out_val_nxt;
  logic [COUNT_W-1:0]  out_cnt_r, out_cnt_nxt;
  status_t         out_stat_r, out_stat_nxt;

  logic            ram_we, ram_re;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [SW-1:0]   ram_wdata, ram_rdata;

  logic [CW-1:0]   idx_p1, idx_p2;
  logic            out_free;

  cls_ram #(
    .WIDTH (SW),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ready        = (state_r == ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_read_value  = out_val_r;
  assign out_entry_count = out_cnt_r;
  assign out_status      = out_stat_r;

  assign out_free = !out_valid_r || out_ready;
  assign idx_p1   = CW'(idx_r) + CW'(1);
  assign idx_p2   = CW'(idx_r) + CW'(2);

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    val_nxt       = val_r;
    pos_nxt       = pos_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    res_val_nxt   = res_val_r;
    res_stat_nxt  = res_stat_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_val_nxt   = out_val_r;
    out_cnt_nxt   = out_cnt_r;
    out_stat_nxt  = out_stat_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_waddr     = idx_r;
    ram_raddr     = idx_r;
    ram_wdata     = ram_rdata;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          mode_nxt  = in_mode;
          val_nxt   = SW'(in_item_value);
          pos_nxt   = in_position;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        res_val_nxt  = '0;
        res_stat_nxt = STAT_OK;
        state_nxt    = ST_DONE;
        case (mode_r)
          MODE_APPEND: begin
            if (count_r == CW'(CAPACITY)) begin
              res_stat_nxt = STAT_FULL;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = AW'(count_r);
              ram_wdata = val_r;
              count_nxt = count_r + CW'(1);
            end
          end
          MODE_READ: begin
            if (32'(pos_r) < 32'(count_r)) begin
              ram_re    = 1'b1;
              ram_raddr = AW'(pos_r);
              state_nxt = ST_RWAIT;
            end else begin
              res_stat_nxt = STAT_RANGE;
            end
          end
          MODE_REMOVE: begin
            idx_nxt = '0;
            if (count_r == '0) begin
              res_stat_nxt = STAT_NOT_FOUND;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = '0;
              state_nxt = ST_SCMP;
            end
          end
          default: begin
            res_stat_nxt = STAT_OK;
          end
        endcase
      end
      ST_RWAIT: begin
        res_val_nxt = ram_rdata;
        state_nxt   = ST_DONE;
      end
      ST_SCMP: begin
        // rdata holds the entry at idx_r, read in the previous cycle
        if (ram_rdata == val_r) begin
          if (idx_p1 < count_r) begin
            ram_re    = 1'b1;
            ram_raddr = AW'(idx_p1);
            state_nxt = ST_SHIFT;
          end else begin
            count_nxt    = count_r - CW'(1);
            res_stat_nxt = STAT_OK;
            state_nxt    = ST_DONE;
          end
        end else if (idx_p1 < count_r) begin
          ram_re    = 1'b1;
          ram_raddr = AW'(idx_p1);
          idx_nxt   = AW'(idx_p1);
        end else begin
          res_stat_nxt = STAT_NOT_FOUND;
          state_nxt    = ST_DONE;
        end
      end
      ST_SHIFT: begin
        // move entry idx+1 down to idx, fetch the next one
        ram_we    = 1'b1;
        ram_waddr = idx_r;
        ram_wdata = ram_rdata;
        idx_nxt   = AW'(idx_p1);
        if (idx_p2 < count_r) begin
          ram_re    = 1'b1;
          ram_raddr = AW'(idx_p2);
        end else begin
          count_nxt    = count_r - CW'(1);
          res_stat_nxt = STAT_OK;
          state_nxt    = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_val_nxt   = VALUE_W'(res_val_r);
          out_cnt_nxt   = COUNT_W'(count_r);
          out_stat_nxt  = res_stat_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    val_r      <= val_nxt;
    pos_r      <= pos_nxt;
    idx_r      <= idx_nxt;
    res_val_r  <= res_val_nxt;
    res_stat_r <= res_stat_nxt;
    out_val_r  <= out_val_nxt;
    out_cnt_r  <= out_cnt_nxt;
    out_stat_r <= out_stat_nxt;
  end

endmodule

// ===== rtl/core/cls_ram.sv =====
module cls_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
